FILE: rtl/vpt_pkg.sv
// Shared constants, types and helper functions of the vertex transform pipeline.
package vpt_pkg;

  // Fixed-point format and datapath widths.
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NUM_W      = DATA_W + FRAC_BITS;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QUO_W      = DIV_STAGES * DIV_STEP;

  // Coefficient store.
  localparam int NUM_COEF   = 16;
  localparam int COEF_IDX_W = 4;
  localparam logic [COEF_IDX_W-1:0] COEF_XX = 4'd12;
  localparam logic [COEF_IDX_W-1:0] COEF_YY = 4'd13;
  localparam logic [COEF_IDX_W-1:0] COEF_ZZ = 4'd14;
  localparam logic [COEF_IDX_W-1:0] COEF_ZW = 4'd15;

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  // Configuration registers.
  localparam int DIM_W      = 14;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd480;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  wide_t;

  localparam wide_t SAT_MAX = wide_t'(64'sh000000007FFFFFFF);
  localparam wide_t SAT_MIN = wide_t'(-64'sh0000000080000000);

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic fx_t sat32(input wide_t v);
    fx_t r;
    if (v > SAT_MAX) begin
      r = fx_t'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = fx_t'(SAT_MIN);
    end else begin
      r = fx_t'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/vpt_in_if.sv
// Input channel: load and transform transactions.
interface vpt_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [vpt_pkg::COEF_IDX_W-1:0]     coef_index;
  logic signed [vpt_pkg::DATA_W-1:0]  coef_value;
  logic signed [vpt_pkg::DATA_W-1:0]  vertex_x;
  logic signed [vpt_pkg::DATA_W-1:0]  vertex_y;
  logic signed [vpt_pkg::DATA_W-1:0]  vertex_z;

  modport source (output valid, opcode, coef_index, coef_value, vertex_x, vertex_y, vertex_z,
                  input ready);
  modport sink (input valid, opcode, coef_index, coef_value, vertex_x, vertex_y, vertex_z,
                output ready);
endinterface

FILE: rtl/vpt_out_if.sv
// Result channel: screen-space vertex transactions.
interface vpt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vpt_pkg::DATA_W-1:0]  screen_x;
  logic signed [vpt_pkg::DATA_W-1:0]  screen_y;
  logic signed [vpt_pkg::DATA_W-1:0]  depth_ndc;
  logic                               w_zero;

  modport source (output valid, screen_x, screen_y, depth_ndc, w_zero, input ready);
  modport sink (input valid, screen_x, screen_y, depth_ndc, w_zero, output ready);
endinterface

FILE: rtl/vertex_perspective_transform.sv
// Pipelined fixed-point vertex transform with perspective divide and viewport mapping.
//
// Usage: the in_ch channel carries two kinds of transactions. A load transaction
// (opcode 0) writes one Q16.16 coefficient into the 16-entry store and yields no
// result; slots 0-11 are the view matrix rows, 12-15 the projection terms.
// A transform transaction (opcode 1) yields exactly one out_ch transaction with
// screen x, screen y (top down), ndc depth and a zero-w flag.
// The cfg port writes the viewport width (index 0) and height (index 1); the user
// must see that it is written only while the pipeline is empty; the block does not enforce this.
// A transform passes the input, product, view, projection, clip and divider setup
// stages, the DIV_STAGES divider stages, then the NDC, viewport and output stages;
// the divider, which resolves four quotient bits per stage, makes up most of them.
// Throughput: one transaction per cycle in both directions while out_ch does not stall.
// Reset clears the coefficient store, restores 640 x 480 and empties the pipe.
// When out_ch stalls, stages with a bubble still advance; in_ch.ready drops only
// once every stage holds a transform. Nothing is lost or repeated.
module vertex_perspective_transform (
  input  logic                               clk,
  input  logic                               rst_n,
  vpt_in_if.sink                             in_ch,
  vpt_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [vpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vpt_pkg::DIM_W-1:0]          cfg_data
);

  localparam int F        = vpt_pkg::FRAC_BITS;
  localparam int DS       = vpt_pkg::DIV_STAGES;
  localparam int VP_W     = vpt_pkg::DATA_W + vpt_pkg::DIM_W + 2;
  localparam int ST_IN    = 1;
  localparam int ST_PROD  = 2;
  localparam int ST_VIEW  = 3;
  localparam int ST_PPROD = 4;
  localparam int ST_CLIP  = 5;
  localparam int ST_DSET  = 6;
  localparam int ST_DIV0  = 7;
  localparam int ST_NDC   = ST_DIV0 + DS;
  localparam int ST_VPP   = ST_NDC + 1;
  localparam int NST      = ST_VPP + 1;

  // Configuration and coefficient state.
  logic [vpt_pkg::DIM_W-1:0] width_r, height_r;
  vpt_pkg::fx_t coef_r [vpt_pkg::NUM_COEF];

  // Stage valid bits and advance enables.
  logic [NST:1] v_r;
  logic [NST:1] ce;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;

  // Each stage takes new data when it is empty or its content moves on.
  always_comb begin
    ce[NST] = !v_r[NST] || out_ch.ready;
    for (int k = NST - 1; k >= 1; k--) begin
      ce[k] = !v_r[k] || ce[k+1];
    end
  end
  assign in_ch.ready = ce[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ce[1]) begin
        v_r[1] <= in_ch.valid && (in_ch.opcode == vpt_pkg::OP_XFORM);
      end
      for (int k = 2; k <= NST; k++) begin
        if (ce[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= vpt_pkg::WIDTH_RESET;
      height_r <= vpt_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vpt_pkg::REG_WIDTH:  width_r  <= cfg_data;
        vpt_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficient store, written by load transactions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vpt_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (in_acc && in_ch.opcode == vpt_pkg::OP_LOAD) begin
      coef_r[in_ch.coef_index] <= in_ch.coef_value;
    end
  end

  // Stage 1: capture the vertex and a snapshot of the coefficients.
  vpt_pkg::fx_t s1_vx_r, s1_vy_r, s1_vz_r;
  vpt_pkg::fx_t s1_coef_r [vpt_pkg::NUM_COEF];

  always_ff @(posedge clk) begin
    if (ce[ST_IN]) begin
      s1_vx_r <= in_ch.vertex_x;
      s1_vy_r <= in_ch.vertex_y;
      s1_vz_r <= in_ch.vertex_z;
      for (int i = 0; i < vpt_pkg::NUM_COEF; i++) begin
        s1_coef_r[i] <= coef_r[i];
      end
    end
  end

  // Stage 2: nine view products, translations and projection terms carried along.
  vpt_pkg::prod_t s2_p_r [3][3];
  vpt_pkg::fx_t   s2_t_r [3];
  vpt_pkg::fx_t   s2_pj_r [4];

  always_ff @(posedge clk) begin
    if (ce[ST_PROD]) begin
      for (int r = 0; r < 3; r++) begin
        s2_p_r[r][0] <= vpt_pkg::prod_t'(s1_coef_r[r*4+0]) * vpt_pkg::prod_t'(s1_vx_r);
        s2_p_r[r][1] <= vpt_pkg::prod_t'(s1_coef_r[r*4+1]) * vpt_pkg::prod_t'(s1_vy_r);
        s2_p_r[r][2] <= vpt_pkg::prod_t'(s1_coef_r[r*4+2]) * vpt_pkg::prod_t'(s1_vz_r);
        s2_t_r[r]    <= s1_coef_r[r*4+3];
      end
      s2_pj_r[0] <= s1_coef_r[vpt_pkg::COEF_XX];
      s2_pj_r[1] <= s1_coef_r[vpt_pkg::COEF_YY];
      s2_pj_r[2] <= s1_coef_r[vpt_pkg::COEF_ZZ];
      s2_pj_r[3] <= s1_coef_r[vpt_pkg::COEF_ZW];
    end
  end

  // Stage 3: floor-shift, sum and saturate each view row.
  vpt_pkg::fx_t s3_e_r [3];
  vpt_pkg::fx_t s3_pj_r [4];

  always_ff @(posedge clk) begin
    if (ce[ST_VIEW]) begin
      for (int r = 0; r < 3; r++) begin
        s3_e_r[r] <= vpt_pkg::sat32(vpt_pkg::wide_t'(s2_p_r[r][0] >>> F)
                                  + vpt_pkg::wide_t'(s2_p_r[r][1] >>> F)
                                  + vpt_pkg::wide_t'(s2_p_r[r][2] >>> F)
                                  + vpt_pkg::wide_t'(s2_t_r[r]));
      end
      for (int i = 0; i < 4; i++) begin
        s3_pj_r[i] <= s2_pj_r[i];
      end
    end
  end

  // Stage 4: projection products and clip w.
  vpt_pkg::prod_t s4_p_r [3];
  vpt_pkg::fx_t   s4_zw_r, s4_cw_r;

  always_ff @(posedge clk) begin
    if (ce[ST_PPROD]) begin
      for (int i = 0; i < 3; i++) begin
        s4_p_r[i] <= vpt_pkg::prod_t'(s3_pj_r[i]) * vpt_pkg::prod_t'(s3_e_r[i]);
      end
      s4_zw_r <= s3_pj_r[3];
      s4_cw_r <= vpt_pkg::sat32(-vpt_pkg::wide_t'(s3_e_r[2]));
    end
  end

  // Stage 5: clip coordinates.
  vpt_pkg::fx_t s5_c_r [3];
  vpt_pkg::fx_t s5_cw_r;
  logic         s5_wz_r;

  always_ff @(posedge clk) begin
    if (ce[ST_CLIP]) begin
      s5_c_r[0] <= vpt_pkg::sat32(vpt_pkg::wide_t'(s4_p_r[0] >>> F));
      s5_c_r[1] <= vpt_pkg::sat32(vpt_pkg::wide_t'(s4_p_r[1] >>> F));
      s5_c_r[2] <= vpt_pkg::sat32(vpt_pkg::wide_t'(s4_p_r[2] >>> F)
                                + vpt_pkg::wide_t'(s4_zw_r));
      s5_cw_r   <= s4_cw_r;
      s5_wz_r   <= (s4_cw_r == '0);
    end
  end

  // Stage 6: magnitudes and quotient signs for the divider.
  logic [vpt_pkg::QUO_W-1:0]  s6_num_r [3];
  logic [2:0]                 s6_neg_r;
  logic [vpt_pkg::DATA_W-1:0] s6_den_r;
  logic                       s6_wz_r;

  always_ff @(posedge clk) begin
    if (ce[ST_DSET]) begin
      for (int i = 0; i < 3; i++) begin
        s6_num_r[i] <= vpt_pkg::QUO_W'({(s5_c_r[i][vpt_pkg::DATA_W-1] ?
                                         vpt_pkg::DATA_W'(-s5_c_r[i]) :
                                         vpt_pkg::DATA_W'(s5_c_r[i])), {F{1'b0}}});
        s6_neg_r[i] <= s5_c_r[i][vpt_pkg::DATA_W-1] ^ s5_cw_r[vpt_pkg::DATA_W-1];
      end
      s6_den_r <= s5_cw_r[vpt_pkg::DATA_W-1] ? vpt_pkg::DATA_W'(-s5_cw_r) :
                                               vpt_pkg::DATA_W'(s5_cw_r);
      s6_wz_r  <= s5_wz_r;
    end
  end

  // Divider: restoring division, DIV_STEP quotient bits per stage, three lanes.
  logic [vpt_pkg::DATA_W-1:0] dv_rem_r [DS][3];
  logic [vpt_pkg::QUO_W-1:0]  dv_q_r   [DS][3];
  logic [vpt_pkg::DATA_W-1:0] dv_den_r [DS];
  logic [2:0]                 dv_neg_r [DS];
  logic                       dv_wz_r  [DS];

  for (genvar g = 0; g < DS; g++) begin : g_div
    logic [vpt_pkg::DATA_W-1:0] rem_in [3];
    logic [vpt_pkg::QUO_W-1:0]  q_in   [3];
    logic [vpt_pkg::DATA_W-1:0] den_in;
    logic [2:0]                 neg_in;
    logic                       wz_in;
    logic [vpt_pkg::DATA_W-1:0] rem_nxt [3];
    logic [vpt_pkg::QUO_W-1:0]  q_nxt   [3];

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = '0;
          q_in[l]   = s6_num_r[l];
        end
        den_in = s6_den_r;
        neg_in = s6_neg_r;
        wz_in  = s6_wz_r;
      end
    end else begin : g_rest
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = dv_rem_r[g-1][l];
          q_in[l]   = dv_q_r[g-1][l];
        end
        den_in = dv_den_r[g-1];
        neg_in = dv_neg_r[g-1];
        wz_in  = dv_wz_r[g-1];
      end
    end

    // Shift in one numerator bit per step and subtract where it fits.
    always_comb begin : div_steps
      logic [vpt_pkg::DATA_W:0]   t;
      logic [vpt_pkg::DATA_W-1:0] rem;
      logic [vpt_pkg::QUO_W-1:0]  q;
      for (int l = 0; l < 3; l++) begin
        rem = rem_in[l];
        q   = q_in[l];
        for (int s = 0; s < vpt_pkg::DIV_STEP; s++) begin
          t = {rem, q[vpt_pkg::QUO_W-1]};
          q = {q[vpt_pkg::QUO_W-2:0], 1'b0};
          if (t >= {1'b0, den_in}) begin
            rem  = vpt_pkg::DATA_W'(t - {1'b0, den_in});
            q[0] = 1'b1;
          end else begin
            rem = t[vpt_pkg::DATA_W-1:0];
          end
        end
        rem_nxt[l] = rem;
        q_nxt[l]   = q;
      end
    end

    always_ff @(posedge clk) begin
      if (ce[ST_DIV0 + g]) begin
        for (int l = 0; l < 3; l++) begin
          dv_rem_r[g][l] <= rem_nxt[l];
          dv_q_r[g][l]   <= q_nxt[l];
        end
        dv_den_r[g] <= den_in;
        dv_neg_r[g] <= neg_in;
        dv_wz_r[g]  <= wz_in;
      end
    end
  end

  // NDC stage: apply sign and saturate the quotients.
  vpt_pkg::fx_t s_ndc_r [3];
  logic         s_ndc_wz_r;

  always_ff @(posedge clk) begin
    if (ce[ST_NDC]) begin
      for (int l = 0; l < 3; l++) begin
        s_ndc_r[l] <= vpt_pkg::sat32(dv_neg_r[DS-1][l] ?
                                     -vpt_pkg::wide_t'(dv_q_r[DS-1][l]) :
                                      vpt_pkg::wide_t'(dv_q_r[DS-1][l]));
      end
      s_ndc_wz_r <= dv_wz_r[DS-1];
    end
  end

  // Viewport products: (ndc + 1) times width or height.
  localparam logic signed [vpt_pkg::DATA_W:0] ONE = (vpt_pkg::DATA_W + 1)'(1) <<< F;
  logic signed [VP_W-1:0] vp_x_r, vp_y_r;
  vpt_pkg::fx_t vp_z_r;
  logic         vp_wz_r;

  always_ff @(posedge clk) begin
    if (ce[ST_VPP]) begin
      vp_x_r  <= VP_W'($signed({s_ndc_r[0][vpt_pkg::DATA_W-1], s_ndc_r[0]}) + ONE)
                 * VP_W'($signed({1'b0, width_r}));
      vp_y_r  <= VP_W'($signed({s_ndc_r[1][vpt_pkg::DATA_W-1], s_ndc_r[1]}) + ONE)
                 * VP_W'($signed({1'b0, height_r}));
      vp_z_r  <= s_ndc_r[2];
      vp_wz_r <= s_ndc_wz_r;
    end
  end

  // Output register: halve, flip y and saturate; zero w forces zeros.
  vpt_pkg::fx_t sx_r, sy_r, sz_r;
  logic         wz_r;
  vpt_pkg::wide_t h_full;
  assign h_full = vpt_pkg::wide_t'($signed({1'b0, height_r})) <<< F;

  always_ff @(posedge clk) begin
    if (ce[NST]) begin
      if (vp_wz_r) begin
        sx_r <= '0;
        sy_r <= '0;
        sz_r <= '0;
      end else begin
        sx_r <= vpt_pkg::sat32(vpt_pkg::wide_t'(vp_x_r >>> 1));
        sy_r <= vpt_pkg::sat32(h_full - vpt_pkg::wide_t'(vp_y_r >>> 1));
        sz_r <= vp_z_r;
      end
      wz_r <= vp_wz_r;
    end
  end

  assign out_ch.valid     = v_r[NST];
  assign out_ch.screen_x  = sx_r;
  assign out_ch.screen_y  = sy_r;
  assign out_ch.depth_ndc = sz_r;
  assign out_ch.w_zero    = wz_r;

  // A zero-w result carries all-zero coordinates.
  a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.w_zero) |->
      (out_ch.screen_x == '0 && out_ch.screen_y == '0 && out_ch.depth_ndc == '0))
    else $error("zero-w result with nonzero coordinates");

  // Input back-pressure only arises from a stalled, full output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back-pressure");

  // The pipe is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  // A load transaction never enters the pipe.
  a_load_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.opcode == vpt_pkg::OP_LOAD) |=> !v_r[1])
    else $error("load transaction entered the pipeline");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the vertex perspective transform pipeline.
`timescale 1ns / 1ps

module tb_top;

  // Scoreboard: tracks the coefficient store and the viewport, and holds expected vertices.
  typedef struct packed {
    vpt_pkg::fx_t sx;
    vpt_pkg::fx_t sy;
    vpt_pkg::fx_t depth;
    logic         wz;
  } screen_vtx_t;

  class vertex_scoreboard;
    longint      coef[vpt_pkg::NUM_COEF];
    longint      vp_width;
    longint      vp_height;
    screen_vtx_t expected_q[$];
    int          errors;

    function new();
      foreach (coef[i]) coef[i] = 0;
      vp_width  = vpt_pkg::WIDTH_RESET;
      vp_height = vpt_pkg::HEIGHT_RESET;
      errors    = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q16.16 product, rounded toward minus infinity.
    function longint qmul(longint a, longint b);
      return (a * b) >>> vpt_pkg::FRAC_BITS;
    endfunction

    function longint view_row(int r, longint x, longint y, longint z);
      return clamp32(qmul(coef[4*r], x) + qmul(coef[4*r+1], y) + qmul(coef[4*r+2], z)
                     + coef[4*r+3]);
    endfunction

    function void set_dim(logic [vpt_pkg::CFG_IDX_W-1:0] idx,
                          logic [vpt_pkg::DIM_W-1:0] val);
      if (idx == vpt_pkg::REG_WIDTH) vp_width = val;
      else vp_height = val;
    endfunction

    // Note an accepted input transaction.
    function void note_input(logic op, logic [vpt_pkg::COEF_IDX_W-1:0] idx,
                             vpt_pkg::fx_t val, vpt_pkg::fx_t x, vpt_pkg::fx_t y,
                             vpt_pkg::fx_t z);
      longint      one, ex, ey, ez, cx, cy, cz, cw, nx, ny, nz;
      screen_vtx_t r;
      one = longint'(1) <<< vpt_pkg::FRAC_BITS;
      if (op == vpt_pkg::OP_LOAD) begin
        coef[idx] = val;
        return;
      end
      ex = view_row(0, x, y, z);
      ey = view_row(1, x, y, z);
      ez = view_row(2, x, y, z);
      cx = clamp32(qmul(coef[vpt_pkg::COEF_XX], ex));
      cy = clamp32(qmul(coef[vpt_pkg::COEF_YY], ey));
      cz = clamp32(qmul(coef[vpt_pkg::COEF_ZZ], ez) + coef[vpt_pkg::COEF_ZW]);
      cw = clamp32(-ez);
      if (cw == 0) begin
        r = '{sx: '0, sy: '0, depth: '0, wz: 1'b1};
      end else begin
        nx = clamp32((cx <<< vpt_pkg::FRAC_BITS) / cw);
        ny = clamp32((cy <<< vpt_pkg::FRAC_BITS) / cw);
        nz = clamp32((cz <<< vpt_pkg::FRAC_BITS) / cw);
        r.sx    = vpt_pkg::fx_t'(clamp32(((nx + one) * vp_width) >>> 1));
        r.sy    = vpt_pkg::fx_t'(clamp32(vp_height * one
                                         - (((ny + one) * vp_height) >>> 1)));
        r.depth = vpt_pkg::fx_t'(nz);
        r.wz    = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    // Compare one result transaction against the oldest expectation.
    task check_result(vpt_pkg::fx_t sx, vpt_pkg::fx_t sy, vpt_pkg::fx_t depth, logic wz);
      screen_vtx_t e;
      if (expected_q.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (sx !== e.sx) report($sformatf("screen_x %h, expected %h", sx, e.sx));
      if (sy !== e.sy) report($sformatf("screen_y %h, expected %h", sy, e.sy));
      if (depth !== e.depth)
        report($sformatf("depth_ndc %h, expected %h", depth, e.depth));
      if (wz !== e.wz) report($sformatf("w_zero %b, expected %b", wz, e.wz));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vpt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vpt_pkg::DIM_W-1:0] cfg_data;

  vpt_in_if  in_ch ();
  vpt_out_if out_ch ();

  vertex_perspective_transform u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vertex_scoreboard sb = new();

  int  hold_off_cycles = 0;
  int  burst_left = 0;
  bit  gaps_on = 1;
  bit  sane_mode = 1;

  localparam vpt_pkg::fx_t Q_ONE = 32'sh0001_0000;

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on the run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Monitors: accepted inputs feed the predictor, accepted results are checked.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.opcode, in_ch.coef_index, in_ch.coef_value,
                    in_ch.vertex_x, in_ch.vertex_y, in_ch.vertex_z);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.screen_x, out_ch.screen_y, out_ch.depth_ndc, out_ch.w_zero);
  end

  // Receiver: a long hold-off when asked, otherwise a stall pattern that changes mode.
  int rx_cycle = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_off_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_off_cycles--;
    end else begin
      case ((rx_cycle / 97) % 4)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(9) < 7);
        2: out_ch.ready = ($urandom_range(9) < 2);
        default: out_ch.ready = ((rx_cycle % 8) < 5);
      endcase
    end
  end

  // Send one input transaction; valid stays high for a following transaction.
  task push(logic op, logic [vpt_pkg::COEF_IDX_W-1:0] idx, vpt_pkg::fx_t val,
            vpt_pkg::fx_t x, vpt_pkg::fx_t y, vpt_pkg::fx_t z);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_ch.opcode     = op;
    in_ch.coef_index = idx;
    in_ch.coef_value = val;
    in_ch.vertex_x   = x;
    in_ch.vertex_y   = y;
    in_ch.vertex_z   = z;
    in_ch.valid      = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task load(logic [vpt_pkg::COEF_IDX_W-1:0] idx, vpt_pkg::fx_t val);
    push(vpt_pkg::OP_LOAD, idx, val, vpt_pkg::fx_t'($urandom), vpt_pkg::fx_t'($urandom),
         vpt_pkg::fx_t'($urandom));
  endtask

  task xform(vpt_pkg::fx_t x, vpt_pkg::fx_t y, vpt_pkg::fx_t z);
    push(vpt_pkg::OP_XFORM, 4'($urandom), vpt_pkg::fx_t'($urandom), x, y, z);
  endtask

  // Let the pipeline drain completely.
  task drain();
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task write_dims(logic [vpt_pkg::DIM_W-1:0] w, logic [vpt_pkg::DIM_W-1:0] h);
    drain();
    cfg_we = 1'b1; cfg_index = vpt_pkg::REG_WIDTH; cfg_data = w;
    sb.set_dim(vpt_pkg::REG_WIDTH, w);
    @(negedge clk);
    cfg_index = vpt_pkg::REG_HEIGHT; cfg_data = h;
    sb.set_dim(vpt_pkg::REG_HEIGHT, h);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function vpt_pkg::fx_t rand_span(int span);
    return vpt_pkg::fx_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  // Identity view with unit projection and a depth offset.
  task load_identity();
    for (int i = 0; i < 12; i++)
      load(4'(i), (i == 0 || i == 5 || i == 10) ? Q_ONE : vpt_pkg::fx_t'(0));
    load(vpt_pkg::COEF_XX, Q_ONE);
    load(vpt_pkg::COEF_YY, Q_ONE);
    load(vpt_pkg::COEF_ZZ, -Q_ONE);
    load(vpt_pkg::COEF_ZW, -(Q_ONE >>> 1));
  endtask

  // One random transaction: mostly plausible scenes, some full-range noise.
  task random_item();
    vpt_pkg::fx_t v;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(9))
        0: v = vpt_pkg::fx_t'($urandom);
        1: v = '0;
        default: v = rand_span(sane_mode ? 32'h0004_0000 : 32'h7fff_0000);
      endcase
      load(4'($urandom), v);
    end else if (sane_mode && $urandom_range(9) != 0) begin
      xform(rand_span(32'h0010_0000), rand_span(32'h0010_0000), rand_span(32'h0010_0000));
    end else begin
      xform(vpt_pkg::fx_t'($urandom), vpt_pkg::fx_t'($urandom), vpt_pkg::fx_t'($urandom));
    end
  endtask

  // Main sequence.
  initial begin
    logic [vpt_pkg::DIM_W-1:0] dims[6][2];
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = vpt_pkg::REG_WIDTH; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.opcode = vpt_pkg::OP_LOAD; in_ch.coef_index = '0;
    in_ch.coef_value = '0; in_ch.vertex_x = '0; in_ch.vertex_y = '0; in_ch.vertex_z = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: cleared store gives zero clip w, then extremes through identity view.
    xform(Q_ONE, -Q_ONE, Q_ONE);
    load_identity();
    xform(0, 0, -Q_ONE);
    xform(0, 0, 0);
    xform(32'sh7fff_ffff, 32'sh7fff_ffff, -Q_ONE);
    xform(32'sh8000_0000, 32'sh8000_0000, -Q_ONE);
    xform(Q_ONE, Q_ONE, 32'sh7fff_ffff);
    xform(Q_ONE, Q_ONE, 32'sh8000_0000);
    load(4'd0, 32'sh7fff_ffff);
    xform(32'sh8000_0000, Q_ONE, -Q_ONE);
    load(4'd0, 32'sh8000_0000);
    xform(32'sh7fff_ffff, Q_ONE, -(Q_ONE >>> 4));
    load(4'd0, Q_ONE);

    // Random phases across viewport settings, extremes among them.
    dims = '{'{14'd640, 14'd480}, '{14'd1, 14'd1}, '{14'd8192, 14'd8192},
             '{14'd0, 14'd0}, '{14'h3fff, 14'h3fff}, '{14'd1920, 14'd1080}};
    for (int p = 0; p < 6; p++) begin
      write_dims(dims[p][0], dims[p][1]);
      sane_mode = (p != 4);
      gaps_on = (p % 2 == 0);
      if (p % 3 == 1) load_identity();
      for (int n = 0; n < 145; n++) begin
        if (p == 2 && n == 40) begin
          // Long receiver hold-off while the sender keeps offering vertices.
          gaps_on = 0;
          hold_off_cycles = 400;
        end
        if (p == 3 && n == 70) drain();
        random_item();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: vertex_perspective_transform.f
rtl/vpt_pkg.sv
rtl/vpt_in_if.sv
rtl/vpt_out_if.sv
rtl/vertex_perspective_transform.sv
bench/tb_top.sv
